/* hdl/krtq_pkg.sv */
// Shared types and constants for the keyed repeating timer queue.
package krtq_pkg;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_DEL   = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;

  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_GAP   = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  localparam logic [62:0] IMMEDIATE_GAP_NS = 63'd100000;
  localparam logic [19:0] NS_PER_MS        = 20'd1000000;
  localparam logic [62:0] MAX_NS           = {63{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic scan_clr;  // start a slot scan
    logic scan_step; // examine one slot
    logic mul_go;    // compute interval times NS_PER_MS for the add or the picked slot
    logic add_write; // write the add slot
    logic fire;      // apply firing to picked slot
    logic del_write; // free the matched slot
  } krtq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic key_hit;
    logic free_hit;
    logic pick_hit;
    logic any_valid;
    logic is_add;
    logic is_del;
    logic is_check;
  } krtq_status_t;

endpackage

/* hdl/krtq_datapath.sv */
// Slot storage, serial scan, deadline arithmetic and result formation.
module krtq_datapath #(
  parameter int unsigned TimerSlots = 16,
  localparam int unsigned IdxW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  krtq_pkg::krtq_cmd_t  cmd_i,
  output krtq_pkg::krtq_status_t sts_o,
  input  logic [1:0]           in_cmd_i,
  input  logic [31:0]          in_handle_i,
  input  logic signed [31:0]   in_session_i,
  input  logic [15:0]          in_repeat_count_i,
  input  logic [30:0]          in_interval_ms_i,
  input  logic [62:0]          in_now_ns_i,
  output logic [62:0]          gap_ns_o,
  output logic                 immediate_o,
  output logic [31:0]          pick_handle_o,
  output logic signed [31:0]   pick_session_o
);

  logic [TimerSlots-1:0] valid_q, fired_q;
  logic [31:0] hnd_q [TimerSlots];
  logic [31:0] ses_q [TimerSlots];
  logic [62:0] dl_q  [TimerSlots];
  logic [15:0] rem_q [TimerSlots];
  logic [30:0] ivl_q [TimerSlots];

  logic [1:0]  cmd_q;
  logic [31:0] h_q;
  logic [31:0] s_q;
  logic [15:0] cnt_q;
  logic [30:0] ms_q;
  logic [62:0] now_q;

  logic [IdxW:0]   scan_q;
  logic [IdxW-1:0] si;
  logic            key_hit_q, free_hit_q, pick_hit_q, any_q;
  logic [IdxW-1:0] key_idx_q, free_idx_q, pick_idx_q;
  logic [62:0]     pick_dl_q, min_dl_q;
  logic [50:0]     prod_q;
  logic [63:0]     sum;
  logic [62:0]     new_dl;
  logic [30:0]     ms_sel;
  logic [IdxW-1:0] wr_idx;
  logic [15:0]     rem_dec;

  assign si = scan_q[IdxW-1:0];
  assign sum = {1'b0, now_q} + {13'd0, prod_q};
  assign new_dl = sum[63] ? krtq_pkg::MAX_NS : sum[62:0];
  assign ms_sel = (cmd_q == krtq_pkg::CMD_ADD) ? ((ms_q == 31'd0) ? 31'd1 : ms_q)
                                               : ivl_q[pick_idx_q];
  assign wr_idx = key_hit_q ? key_idx_q : free_idx_q;
  assign rem_dec = rem_q[pick_idx_q] - 16'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd_i;  h_q <= in_handle_i;  s_q <= in_session_i;
      cnt_q <= in_repeat_count_i;  ms_q <= in_interval_ms_i;  now_q <= in_now_ns_i;
    end
    if (cmd_i.mul_go) prod_q <= ms_sel * krtq_pkg::NS_PER_MS;
    if (cmd_i.add_write) begin
      hnd_q[wr_idx] <= h_q;  ses_q[wr_idx] <= s_q;  rem_q[wr_idx] <= cnt_q;
      ivl_q[wr_idx] <= ms_sel;  dl_q[wr_idx] <= new_dl;
    end
    if (cmd_i.fire) begin
      dl_q[pick_idx_q] <= new_dl;
      if (rem_q[pick_idx_q] != 16'd0) rem_q[pick_idx_q] <= rem_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;  fired_q <= '0;  scan_q <= '0;
      key_hit_q <= 1'b0;  free_hit_q <= 1'b0;  pick_hit_q <= 1'b0;  any_q <= 1'b0;
      key_idx_q <= '0;  free_idx_q <= '0;  pick_idx_q <= '0;
      pick_dl_q <= '0;  min_dl_q <= '0;
    end else begin
      if (cmd_i.load) fired_q <= '0;
      if (cmd_i.scan_clr) begin
        scan_q <= '0;  key_hit_q <= 1'b0;  free_hit_q <= 1'b0;
        pick_hit_q <= 1'b0;  any_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
        if (valid_q[si] && hnd_q[si] == h_q && ses_q[si] == s_q && !key_hit_q) begin
          key_hit_q <= 1'b1;  key_idx_q <= si;
        end
        if (!valid_q[si] && !free_hit_q) begin
          free_hit_q <= 1'b1;  free_idx_q <= si;
        end
        if (valid_q[si] && !fired_q[si] && dl_q[si] <= now_q &&
            (!pick_hit_q || dl_q[si] < pick_dl_q)) begin
          pick_hit_q <= 1'b1;  pick_idx_q <= si;  pick_dl_q <= dl_q[si];
        end
        if (valid_q[si] && (!any_q || dl_q[si] < min_dl_q)) begin
          any_q <= 1'b1;  min_dl_q <= dl_q[si];
        end
      end
      if (cmd_i.add_write) valid_q[wr_idx] <= 1'b1;
      if (cmd_i.del_write) valid_q[key_idx_q] <= 1'b0;
      if (cmd_i.fire) begin
        fired_q[pick_idx_q] <= 1'b1;
        if (rem_q[pick_idx_q] == 16'd1) valid_q[pick_idx_q] <= 1'b0;
      end
    end
  end

  assign sts_o.scan_done = (scan_q == (IdxW+1)'(TimerSlots));
  assign sts_o.key_hit   = key_hit_q;
  assign sts_o.free_hit  = free_hit_q;
  assign sts_o.pick_hit  = pick_hit_q;
  assign sts_o.any_valid = any_q;
  assign sts_o.is_add    = (cmd_q == krtq_pkg::CMD_ADD);
  assign sts_o.is_del    = (cmd_q == krtq_pkg::CMD_DEL);
  assign sts_o.is_check  = (cmd_q == krtq_pkg::CMD_CHECK);

  assign immediate_o    = (now_q >= min_dl_q);
  assign gap_ns_o       = immediate_o ? krtq_pkg::IMMEDIATE_GAP_NS : (min_dl_q - now_q);
  assign pick_handle_o  = hnd_q[pick_idx_q];
  assign pick_session_o = ses_q[pick_idx_q];

endmodule

/* hdl/krtq_ctrl.sv */
// Sequencer for add, delete and check commands with the result register.
module krtq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output krtq_pkg::krtq_cmd_t    cmd_o,
  input  krtq_pkg::krtq_status_t sts_i,
  input  logic [62:0]            gap_ns_i,
  input  logic                   immediate_i,
  input  logic [31:0]            pick_handle_i,
  input  logic signed [31:0]     pick_session_i,
  output logic [1:0]             kind_o,
  output logic [31:0]            fired_handle_o,
  output logic signed [31:0]     fired_session_o,
  output logic [62:0]            gap_ns_o,
  output logic                   immediate_o,
  output logic                   last_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_GAPSCAN = 3'd5;

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d, free;
  logic       pend_q, pend_d;
  logic [1:0] kind_q, kind_d;
  logic [31:0] fh_q, fh_d;
  logic [31:0] fs_q, fs_d;
  logic [62:0] gap_q, gap_d;
  logic        imm_q, imm_d, last_q, last_d;

  assign free = !ov_q || !out_stall;
  assign in_stall = (state_q != ST_IDLE);
  assign out_valid = ov_q;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    ov_d = ov_q && out_stall;
    pend_d = pend_q;
    kind_d = kind_q;  fh_d = fh_q;  fs_d = fs_q;  gap_d = gap_q;
    imm_d = imm_q;  last_d = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;  cmd_o.scan_clr = 1'b1;  state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts_i.scan_done) cmd_o.scan_step = 1'b1;
        else if (sts_i.is_del) begin
          if (sts_i.key_hit) cmd_o.del_write = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.is_add) begin
          if (sts_i.key_hit || sts_i.free_hit) begin
            cmd_o.mul_go = 1'b1;  state_d = ST_MUL;
          end else if (free) begin
            ov_d = 1'b1;  kind_d = krtq_pkg::KIND_FULL;  fh_d = '0;  fs_d = '0;
            gap_d = '0;  imm_d = 1'b0;  last_d = 1'b1;  state_d = ST_IDLE;
          end
        end else if (sts_i.is_check) begin
          if (sts_i.pick_hit) begin
            cmd_o.mul_go = 1'b1;  state_d = ST_MUL;
          end else state_d = ST_EMIT;
        end else state_d = ST_IDLE;
      end
      ST_MUL: begin
        if (sts_i.is_add) begin
          cmd_o.add_write = 1'b1;  cmd_o.scan_clr = 1'b1;  state_d = ST_GAPSCAN;
        end else if (pend_q) begin
          // another firing follows: release the held one first
          ov_d = 1'b1;  pend_d = 1'b0;
        end else if (free) begin
          // hold the firing unpublished until its last flag is known
          pend_d = 1'b1;  kind_d = krtq_pkg::KIND_FIRED;  fh_d = pick_handle_i;
          fs_d = pick_session_i;  gap_d = '0;  imm_d = 1'b0;  last_d = 1'b0;
          cmd_o.fire = 1'b1;  state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.scan_clr = 1'b1;  state_d = ST_SCAN;
      end
      ST_GAPSCAN: begin
        if (!sts_i.scan_done) cmd_o.scan_step = 1'b1;
        else state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (pend_q) begin
          ov_d = 1'b1;  pend_d = 1'b0;
          // no timers left: the held firing ends the check
          if (!sts_i.any_valid) begin
            last_d = 1'b1;  state_d = ST_IDLE;
          end
        end else if (!sts_i.any_valid) begin
          state_d = ST_IDLE;
        end else if (free) begin
          ov_d = 1'b1;  kind_d = krtq_pkg::KIND_GAP;  fh_d = '0;  fs_d = '0;
          gap_d = gap_ns_i;  imm_d = immediate_i;  last_d = 1'b1;  state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;  ov_q <= 1'b0;  pend_q <= 1'b0;
    end else begin
      state_q <= state_d;  ov_q <= ov_d;  pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;  fh_q <= fh_d;  fs_q <= fs_d;
    gap_q <= gap_d;  imm_q <= imm_d;  last_q <= last_d;
  end

  assign kind_o = kind_q;
  assign fired_handle_o = fh_q;
  assign fired_session_o = fs_q;
  assign gap_ns_o = gap_q;
  assign immediate_o = imm_q;
  assign last_o = last_q;

endmodule

/* hdl/keyed_repeating_timer_queue_unit.sv */
// Top level of the keyed repeating timer queue.
// Each command scans the slots one per cycle. Delete takes one scan; add
// takes a key scan, a multiply, and a gap scan, but ends after the key scan
// when the table is full; check runs one scan per firing plus a final scan.
// Results leave through a one-entry output register; each firing waits there
// unpublished until the next step of the check shows whether it is the last
// result. The serial slot scan sets the rate.
module keyed_repeating_timer_queue_unit #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        handle_i,
  input  logic signed [31:0] session_i,
  input  logic [15:0]        repeat_count_i,
  input  logic [30:0]        interval_ms_i,
  input  logic [62:0]        now_ns_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind_o,
  output logic [31:0]        fired_handle_o,
  output logic signed [31:0] fired_session_o,
  output logic [62:0]        gap_ns_o,
  output logic               immediate_o,
  output logic               last_o
);

  krtq_pkg::krtq_cmd_t    cmd;
  krtq_pkg::krtq_status_t sts;
  logic [62:0]        gap;
  logic               imm;
  logic [31:0]        ph;
  logic signed [31:0] ps;

  krtq_datapath #(.TimerSlots(TIMER_SLOTS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_cmd_i(cmd_i), .in_handle_i(handle_i), .in_session_i(session_i),
    .in_repeat_count_i(repeat_count_i), .in_interval_ms_i(interval_ms_i),
    .in_now_ns_i(now_ns_i), .gap_ns_o(gap), .immediate_o(imm),
    .pick_handle_o(ph), .pick_session_o(ps)
  );

  krtq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd_o(cmd), .sts_i(sts), .gap_ns_i(gap), .immediate_i(imm),
    .pick_handle_i(ph), .pick_session_i(ps),
    .kind_o, .fired_handle_o, .fired_session_o, .gap_ns_o, .immediate_o, .last_o
  );

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted beat did not start a command");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(kind_o)))
    else $error("stalled result changed");
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.add_write, cmd.fire, cmd.del_write}))
    else $error("conflicting slot writes");

endmodule

/* test/tb_keyed_repeating_timer_queue_unit.sv */
// Testbench for the keyed repeating timer queue: directed table, then random commands.
module tb_keyed_repeating_timer_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [62:0] NS_MAX = {63{1'b1}};

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        handle;
    logic signed [31:0] session;
    logic [62:0]        gap;
    logic               imm;
    logic               last;
  } timer_event_t;

  typedef struct {
    logic [1:0]         cmd;
    logic [31:0]        handle;
    logic signed [31:0] session;
    logic [15:0]        count;
    logic [30:0]        ms;
    logic [62:0]        now;
  } timer_cmd_t;

  typedef struct {
    timer_cmd_t  c;
    bit          typed;
    logic [1:0]  kind;
    logic [62:0] gap;
    logic        imm;
  } directed_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd_i = '0;
  logic [31:0]        handle_i = '0;
  logic signed [31:0] session_i = '0;
  logic [15:0]        repeat_count_i = '0;
  logic [30:0]        interval_ms_i = '0;
  logic [62:0]        now_ns_i = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         kind_o;
  logic [31:0]        fired_handle_o;
  logic signed [31:0] fired_session_o;
  logic [62:0]        gap_ns_o;
  logic               immediate_o;
  logic               last_o;

  keyed_repeating_timer_queue_unit #(.TIMER_SLOTS(SLOTS)) u_top (.*);

  always #5 clk_i = ~clk_i;

  // predicted slot table
  bit                 tbl_valid [SLOTS];
  logic [31:0]        tbl_handle [SLOTS];
  logic signed [31:0] tbl_session [SLOTS];
  logic [62:0]        tbl_deadline [SLOTS];
  logic [15:0]        tbl_remaining [SLOTS];
  logic [30:0]        tbl_interval [SLOTS];

  timer_event_t pending_events[$];
  int errors = 0;
  int fired_seen = 0, gaps_seen = 0, fulls_seen = 0, beats_sent = 0;
  bit quiet = 0, hold_req = 0;

  function automatic logic [62:0] deadline_after(logic [62:0] now, logic [30:0] ms);
    logic [63:0] sum;
    sum = {1'b0, now} + 64'(ms) * 64'd1000000;
    return sum > {1'b0, NS_MAX} ? NS_MAX : sum[62:0];
  endfunction

  function automatic void push_event(ref timer_event_t q[$], input logic [1:0] kind,
                                     input logic [31:0] h, input logic [31:0] s,
                                     input logic [62:0] gap, input logic imm);
    timer_event_t e;
    e.kind = kind; e.handle = h; e.session = s; e.gap = gap; e.imm = imm; e.last = 1'b0;
    q.push_back(e);
  endfunction

  function automatic void gap_report(ref timer_event_t q[$], input logic [62:0] now);
    bit any;
    logic [62:0] best;
    any = 0;
    best = '0;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && (!any || tbl_deadline[i] < best)) begin
        best = tbl_deadline[i];
        any = 1;
      end
    if (!any) return;
    if (now >= best)
      push_event(q, krtq_pkg::KIND_GAP, '0, '0, krtq_pkg::IMMEDIATE_GAP_NS, 1'b1);
    else push_event(q, krtq_pkg::KIND_GAP, '0, '0, best - now, 1'b0);
  endfunction

  function automatic int find_key(logic [31:0] h, logic [31:0] s);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_handle[i] == h && tbl_session[i] == s) return i;
    return -1;
  endfunction

  // Advance the table by one command and return the results it causes.
  function automatic void timer_table_step(input timer_cmd_t c, ref timer_event_t q[$]);
    int slot, pick;
    bit fired [SLOTS];
    logic [30:0] ms;
    q.delete();
    if (c.cmd == krtq_pkg::CMD_ADD) begin
      slot = find_key(c.handle, c.session);
      if (slot < 0)
        for (int i = 0; i < SLOTS; i++)
          if (!tbl_valid[i]) begin
            slot = i;
            break;
          end
      if (slot < 0) begin
        push_event(q, krtq_pkg::KIND_FULL, '0, '0, '0, 1'b0);
      end else begin
        ms = (c.ms == 0) ? 31'd1 : c.ms;
        tbl_valid[slot] = 1;
        tbl_handle[slot] = c.handle;
        tbl_session[slot] = c.session;
        tbl_remaining[slot] = c.count;
        tbl_interval[slot] = ms;
        tbl_deadline[slot] = deadline_after(c.now, ms);
        gap_report(q, c.now);
      end
    end else if (c.cmd == krtq_pkg::CMD_DEL) begin
      slot = find_key(c.handle, c.session);
      if (slot >= 0) tbl_valid[slot] = 0;
    end else if (c.cmd == krtq_pkg::CMD_CHECK) begin
      foreach (fired[i]) fired[i] = 0;
      forever begin
        pick = -1;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] && !fired[i] && tbl_deadline[i] <= c.now &&
              (pick < 0 || tbl_deadline[i] < tbl_deadline[pick]))
            pick = i;
        if (pick < 0) break;
        fired[pick] = 1;
        push_event(q, krtq_pkg::KIND_FIRED, tbl_handle[pick], tbl_session[pick],
                   '0, 1'b0);
        if (tbl_remaining[pick] > 0) begin
          tbl_remaining[pick]--;
          if (tbl_remaining[pick] == 0) begin
            tbl_valid[pick] = 0;
            continue;
          end
        end
        tbl_deadline[pick] = deadline_after(c.now, tbl_interval[pick]);
      end
      gap_report(q, c.now);
    end
    if (q.size() > 0) q[q.size() - 1].last = 1'b1;
  endfunction

  function automatic void note_error(string what, timer_event_t e, timer_event_t a);
    errors++;
    if (errors <= 10)
      $display("%0t %s: exp kind=%0d h=%h s=%h gap=%0d imm=%0b last=%0b %s",
               $realtime, what, e.kind, e.handle, e.session, e.gap, e.imm, e.last,
               $sformatf("| got kind=%0d h=%h s=%h gap=%0d imm=%0b last=%0b",
                         a.kind, a.handle, a.session, a.gap, a.imm, a.last));
  endfunction

  // Send one command beat, hold it until accepted, then predict.
  task automatic send_cmd(input timer_cmd_t c, ref timer_event_t q[$]);
    @(negedge clk_i);
    cmd_i = c.cmd; handle_i = c.handle; session_i = c.session;
    repeat_count_i = c.count; interval_ms_i = c.ms; now_ns_i = c.now;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    beats_sent++;
    timer_table_step(c, q);
    foreach (q[i]) pending_events.push_back(q[i]);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    timer_event_t a, e;
    if (rst_ni && out_valid && !out_stall) begin
      a.kind = kind_o; a.handle = fired_handle_o; a.session = fired_session_o;
      a.gap = gap_ns_o; a.imm = immediate_o; a.last = last_o;
      case (kind_o)
        krtq_pkg::KIND_FIRED: fired_seen++;
        krtq_pkg::KIND_GAP:   gaps_seen++;
        default:              fulls_seen++;
      endcase
      if (pending_events.size() == 0) begin
        e = '0;
        note_error("unexpected beat", e, a);
      end else begin
        e = pending_events.pop_front();
        if (a !== e) note_error("mismatch", e, a);
      end
    end
  end

  // receiver: short random stalls, one long hold on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall = 1'b0;
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    #30ms;
    $display("** keyed_repeating_timer_queue_unit: FAILED **");
    $finish;
  end

  function automatic timer_cmd_t mk(logic [1:0] cmd, logic [31:0] h, logic [31:0] s,
                                    logic [15:0] cnt, logic [30:0] ms, logic [62:0] now);
    timer_cmd_t c;
    c.cmd = cmd; c.handle = h; c.session = s; c.count = cnt; c.ms = ms; c.now = now;
    return c;
  endfunction

  function automatic directed_row_t row(timer_cmd_t c, bit typed = 0,
                                        logic [1:0] kind = krtq_pkg::KIND_GAP,
                                        logic [62:0] gap = '0, logic imm = 1'b0);
    directed_row_t r;
    r.c = c; r.typed = typed; r.kind = kind; r.gap = gap; r.imm = imm;
    return r;
  endfunction

  initial begin
    directed_row_t rows[$];
    timer_event_t res[$];
    timer_event_t want;
    timer_cmd_t c;
    logic [62:0] clock_ns;
    logic [31:0] handles [8];
    logic [31:0] sessions [4];
    int waited;

    foreach (tbl_valid[i]) tbl_valid[i] = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table, unknown key, extremes, zero interval, replace, saturation, unused code
    rows.push_back(row(mk(krtq_pkg::CMD_CHECK, 0, 0, 0, 0, 0)));
    rows.push_back(row(mk(krtq_pkg::CMD_DEL, 32'hdead, 5, 0, 0, 0)));
    rows.push_back(row(mk(krtq_pkg::CMD_ADD, 0, 0, 1, 5, 0),
                       1, krtq_pkg::KIND_GAP, 63'd5000000, 1'b0));
    rows.push_back(row(mk(krtq_pkg::CMD_ADD, '1, 32'h80000000, 0, 0, 0),
                       1, krtq_pkg::KIND_GAP, 63'd1000000, 1'b0));
    rows.push_back(row(mk(krtq_pkg::CMD_ADD, '1, 32'h80000000, 0, 10, 0),
                       1, krtq_pkg::KIND_GAP, 63'd5000000, 1'b0));
    rows.push_back(row(mk(krtq_pkg::CMD_ADD, 1, 32'h7fffffff, 16'hffff, 31'h7fffffff,
                          NS_MAX - 1),
                       1, krtq_pkg::KIND_GAP, krtq_pkg::IMMEDIATE_GAP_NS, 1'b1));
    rows.push_back(row(mk(krtq_pkg::CMD_CHECK, 0, 0, 0, 0, 63'd10000000)));
    rows.push_back(row(mk(CMD_UNUSED, 1, 32'h7fffffff, 0, 0, NS_MAX)));
    rows.push_back(row(mk(krtq_pkg::CMD_CHECK, 0, 0, 0, 0, NS_MAX)));
    rows.push_back(row(mk(krtq_pkg::CMD_DEL, 1, 32'h7fffffff, 0, 0, 0)));
    rows.push_back(row(mk(krtq_pkg::CMD_DEL, '1, 32'h80000000, 0, 0, 0)));
    rows.push_back(row(mk(krtq_pkg::CMD_CHECK, 0, 0, 0, 0, NS_MAX)));
    // fill the table with equal deadlines, overflow it, then fire all as ties
    for (int i = 0; i < SLOTS; i++)
      rows.push_back(row(mk(krtq_pkg::CMD_ADD, 32'h100 + i, -i, 2, 3, 63'd1000)));
    rows.push_back(row(mk(krtq_pkg::CMD_ADD, 32'h999, 9, 1, 1, 63'd1000),
                       1, krtq_pkg::KIND_FULL));
    rows.push_back(row(mk(krtq_pkg::CMD_CHECK, 0, 0, 0, 0, 63'd3001000)));

    foreach (rows[i]) begin
      send_cmd(rows[i].c, res);
      if (rows[i].typed) begin
        want.kind = rows[i].kind; want.handle = '0; want.session = '0;
        want.gap = rows[i].gap; want.imm = rows[i].imm; want.last = 1'b1;
        if (res.size() != 1) note_error("directed row count", want, want);
        else if (res[0] !== want) note_error("directed row", want, res[0]);
      end
    end

    foreach (handles[i]) handles[i] = $urandom;
    foreach (sessions[i]) sessions[i] = $urandom;
    clock_ns = 63'd5000000;
    for (int n = 0; n < 500; n++) begin
      if (n == 450) quiet = 1;
      if (n == 200) hold_req = 1;
      c.handle = handles[$urandom_range(0, 7)];
      c.session = sessions[$urandom_range(0, 3)];
      if ($urandom_range(0, 19) == 0) begin
        c.handle = $urandom;
        c.session = $urandom;
      end
      c.count = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      c.ms = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 20));
      clock_ns = clock_ns + 63'($urandom_range(0, 8000000));
      c.now = clock_ns;
      if ($urandom_range(0, 49) == 0) c.now = 63'({$urandom, $urandom});
      case ($urandom_range(0, 19))
        0:                  c.cmd = CMD_UNUSED;
        1, 2, 3, 4:         c.cmd = krtq_pkg::CMD_DEL;
        5, 6, 7, 8, 9, 10:  c.cmd = krtq_pkg::CMD_CHECK;
        default:            c.cmd = krtq_pkg::CMD_ADD;
      endcase
      send_cmd(c, res);
    end
    @(negedge clk_i);
    in_valid = 1'b0;

    waited = 0;
    while (pending_events.size() > 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (200) @(posedge clk_i);
    if (pending_events.size() > 0) begin
      errors++;
      $display("%0d expected beats never arrived", pending_events.size());
    end

    $display("Sent %0d command beats; saw %0d firings, %0d gap reports, %0d table-full beats.",
             beats_sent, fired_seen, gaps_seen, fulls_seen);
    if (errors == 0) begin
      $display("** keyed_repeating_timer_queue_unit: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** keyed_repeating_timer_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
